// ----- src/fpop_pkg.sv -----
// ----------------------------------------------------------------------------
// fpop_pkg
// Shared types and codes of the fast-path output PDU parser.
// ----------------------------------------------------------------------------
package fpop_pkg;

  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_NOUPD = 2'd2;
  localparam logic [1:0] EV_ERR   = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_FP    = 3'd1;
  localparam logic [2:0] ERR_ENCRYPTED = 3'd2;
  localparam logic [2:0] ERR_LENGTH    = 3'd3;
  localparam logic [2:0] ERR_COMPRESS  = 3'd4;
  localparam logic [2:0] ERR_TRUNC     = 3'd5;

  typedef struct packed {
    logic       vld;
    logic [1:0] event_res;
    logic [7:0] data;
    logic [3:0] code;
    logic [1:0] frag;
    logic       last;
    logic       pend;
    logic [2:0] err;
  } fpop_res_t;

endpackage

// ----- src/fpop_core.sv -----
// ----------------------------------------------------------------------------
// fpop_core
// Parse state and per-byte next-state logic; one byte per step.
// ----------------------------------------------------------------------------
module fpop_core import fpop_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] b,
  input  logic       eop,
  output fpop_res_t  res
);

  typedef enum logic [3:0] {
    PH_HDR  = 4'd0,
    PH_LEN1 = 4'd1,
    PH_LEN2 = 4'd2,
    PH_UHDR = 4'd3,
    PH_COMP = 4'd4,
    PH_SZLO = 4'd5,
    PH_SZHI = 4'd6,
    PH_DATA = 4'd7,
    PH_DROP = 4'd8
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [14:0] decl_r, decl_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [3:0]  code_r, code_nxt;
  logic [1:0]  frag_r, frag_nxt;
  logic [7:0]  szlo_r, szlo_nxt;
  logic [15:0] rem_r, rem_nxt;

  logic [15:0] seen_base;
  logic [15:0] seen_inc;
  logic [15:0] rem_dec;
  logic        has_ev;
  logic [1:0]  ev;
  logic [2:0]  err;
  logic [7:0]  data;
  logic        last;
  logic        pend;

  assign seen_base = (ph_r == PH_HDR) ? 16'd0 : seen_r;
  assign seen_inc  = (seen_base == 16'hFFFF) ? seen_base : seen_base + 16'd1;
  assign rem_dec   = rem_r - 16'd1;

  always_comb begin
    ph_nxt   = ph_r;
    decl_nxt = decl_r;
    seen_nxt = seen_r;
    code_nxt = code_r;
    frag_nxt = frag_r;
    szlo_nxt = szlo_r;
    rem_nxt  = rem_r;
    has_ev   = 1'b0;
    ev       = EV_DATA;
    err      = ERR_NONE;
    data     = 8'd0;
    last     = 1'b0;
    pend     = 1'b0;
    if (step && ph_r == PH_DROP) begin
      if (eop) begin
        ph_nxt = PH_HDR;
      end
    end else if (step) begin
      seen_nxt = seen_inc;
      if ((ph_r inside {PH_UHDR, PH_COMP, PH_SZLO, PH_SZHI, PH_DATA}) &&
          seen_inc > {1'b0, decl_r}) begin
        err = ERR_LENGTH;
      end else begin
        case (ph_r)
          PH_HDR: begin
            if (b[1:0] != 2'd0) begin
              err = ERR_NOT_FP;
            end else if (b[7:6] != 2'd0) begin
              err = ERR_ENCRYPTED;
            end else begin
              ph_nxt = PH_LEN1;
            end
          end
          PH_LEN1: begin
            if (b[7]) begin
              decl_nxt = {b[6:0], 8'd0};
              ph_nxt   = PH_LEN2;
            end else begin
              decl_nxt = {7'd0, b};
              ph_nxt   = PH_UHDR;
              if (seen_inc > {8'd0, b}) begin
                err = ERR_LENGTH;
              end
            end
          end
          PH_LEN2: begin
            decl_nxt = {decl_r[14:8], decl_r[7:0] | b};
            ph_nxt   = PH_UHDR;
            if (seen_inc > {1'b0, decl_r[14:8], decl_r[7:0] | b}) begin
              err = ERR_LENGTH;
            end
          end
          PH_UHDR: begin
            code_nxt = b[3:0];
            frag_nxt = b[5:4];
            ph_nxt   = b[7] ? PH_COMP : PH_SZLO;
          end
          PH_COMP: begin
            if (b[5]) begin
              err = ERR_COMPRESS;
            end else begin
              ph_nxt = PH_SZLO;
            end
          end
          PH_SZLO: begin
            szlo_nxt = b;
            ph_nxt   = PH_SZHI;
          end
          PH_SZHI: begin
            rem_nxt = {b, szlo_r};
            if ({b, szlo_r} == 16'd0) begin
              has_ev = 1'b1;
              ev     = EV_EMPTY;
              ph_nxt = PH_UHDR;
            end else begin
              ph_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            has_ev  = 1'b1;
            ev      = EV_DATA;
            data    = b;
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              last   = 1'b1;
              ph_nxt = PH_UHDR;
            end
          end
          default: begin
          end
        endcase
      end
      if (err == ERR_NONE && eop) begin
        if (ph_nxt inside {PH_HDR, PH_LEN1, PH_LEN2}) begin
          err = ERR_TRUNC;
        end else if (seen_inc != {1'b0, decl_nxt}) begin
          err = ERR_LENGTH;
        end else if (ph_nxt != PH_UHDR) begin
          err = ERR_TRUNC;
        end else begin
          if (!has_ev) begin
            has_ev = 1'b1;
            ev     = EV_NOUPD;
          end
          pend   = 1'b1;
          ph_nxt = PH_HDR;
        end
      end
      if (err != ERR_NONE) begin
        ph_nxt = eop ? PH_HDR : PH_DROP;
      end
    end
  end

  always_comb begin
    res = '0;
    if (err != ERR_NONE) begin
      res.vld       = 1'b1;
      res.event_res = EV_ERR;
      res.err       = err;
    end else if (has_ev) begin
      res.vld       = 1'b1;
      res.event_res = ev;
      res.data      = data;
      res.code      = (ev == EV_NOUPD) ? 4'd0 : code_r;
      res.frag      = (ev == EV_NOUPD) ? 2'd0 : frag_r;
      res.last      = last;
      res.pend      = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HDR;
      decl_r <= '0;
      seen_r <= '0;
      code_r <= '0;
      frag_r <= '0;
      szlo_r <= '0;
      rem_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      decl_r <= decl_nxt;
      seen_r <= seen_nxt;
      code_r <= code_nxt;
      frag_r <= frag_nxt;
      szlo_r <= szlo_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ----- src/fast_path_output_pdu_parser.sv -----
// ----------------------------------------------------------------------------
// fast_path_output_pdu_parser
// Byte-stream parser for fast-path output PDUs; emits update data bytes and update, PDU-end and error results.
// ----------------------------------------------------------------------------
// Input channel: one PDU byte per request (in_byte, in_end_of_pdu on the final
// byte), qualified by in_valid, held off by in_stall.
// Result channel: at most one result per input byte (out_event_res selects a
// data byte, an empty update, an update-less PDU end, or an error with
// out_error_code). Bytes that cause no result produce nothing on out_*.
// Parsing: a byte accepted into the input register is parsed when it advances,
// and its result is registered in the result register and held there until taken.
// Throughput: one byte per cycle sustained while out_stall is low; the parse
// state update for one byte is a single pass of compares and a 16-bit increment.
// Stall: while out_valid is high and out_stall holds it, one more byte may sit
// in the input register; in_stall rises only when that register is full and
// cannot move forward.
// Reset: rst_n low for one edge empties both registers and puts the parser in
// front of a PDU header byte.
// After an error, the rest of the PDU up to its final byte is dropped.
// ----------------------------------------------------------------------------
module fast_path_output_pdu_parser import fpop_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_pdu,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_byte,
  output logic [3:0] out_update_code,
  output logic [1:0] out_fragmentation,
  output logic       out_last_of_update,
  output logic       out_pdu_end,
  output logic [2:0] out_error_code
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eop_r;
  logic       advance;
  logic       in_take;
  fpop_res_t  res;
  fpop_res_t  out_r;
  logic       out_vld_r;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
      in_eop_r  <= in_end_of_pdu;
    end
  end

  fpop_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .b     (in_byte_r),
    .eop   (in_eop_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res.vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_event_res      = out_r.event_res;
  assign out_byte           = out_r.data;
  assign out_update_code    = out_r.code;
  assign out_fragmentation  = out_r.frag;
  assign out_last_of_update = out_r.last;
  assign out_pdu_end        = out_r.pend;
  assign out_error_code     = out_r.err;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked request");

  a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |-> !in_stall)
    else $error("input stalled with an empty result register");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_ERR) |->
      (!out_pdu_end && !out_last_of_update && out_error_code != ERR_NONE))
    else $error("error result carries data flags");

  a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_ERR) |-> (out_error_code == ERR_NONE))
    else $error("error code on a non-error result");

  a_noupd_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_NOUPD) |-> out_pdu_end)
    else $error("update-less result without PDU end");

endmodule
